/* design/mecanum_wheel_mixer_limit_assert.svh */
// Assertion helpers for the wheel mixer.
`ifndef MECANUM_WHEEL_MIXER_LIMIT_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_LIMIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MWML_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks a condition in the cycle after the trigger, with no reset masking.
`define MWML_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/mwml_pkg.sv */
`timescale 1ns / 1ps

package mwml_pkg;

   localparam int SPEED_W    = 32;
   localparam int SCALE_W    = 16;
   localparam int ARM_W      = 16;
   localparam int LIMIT_W    = 31;
   localparam int NUM_WHEELS = 4;

   localparam int REQ_DATA_W = 3 * SPEED_W;
   localparam int RSP_DATA_W = NUM_WHEELS * SPEED_W;
   localparam int RSP_USER_W = 2;

   // Rotation path: Q2.14 factor times Q0.16 arm times Q16.16 yaw is Q.46.
   localparam int FACTOR_W   = SCALE_W + 1;
   localparam int COEF_W     = FACTOR_W + ARM_W;
   localparam int PROD_W     = COEF_W + SPEED_W;
   localparam int FRAC_SHIFT = 30;
   localparam int WHEEL_W    = 36;
   localparam int MAG_W      = WHEEL_W - 1;
   localparam int RAW_SHIFT  = 16;

   // Limiter ratio is Q0.30 and always below one when it is used.
   localparam int RATE_W          = 30;
   localparam int RATE_SHIFT      = 30;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = RATE_W / STEPS_PER_STAGE;
   localparam int REM_W           = MAG_W + 1;

   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic signed [FACTOR_W-1:0] ONE_Q14 = FACTOR_W'(16384);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = LIMIT_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVER_ARM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED = 2'd2;

   localparam logic [SCALE_W-1:0] ROT_SCALE_RESET = '0;
   localparam logic [ARM_W-1:0]   LEVER_ARM_RESET = ARM_W'(13107);
   localparam logic [LIMIT_W-1:0] MAX_SPEED_RESET = LIMIT_W'(262144);

   typedef struct packed {
      logic [SCALE_W-1:0] rot_scale;
      logic [ARM_W-1:0]   lever_arm;
      logic [LIMIT_W-1:0] max_speed;
   } mwml_cfg_type;

   // One mixed command waiting for the limiter.
   typedef struct packed {
      logic [NUM_WHEELS-1:0]            neg;
      logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]                 peak;
      logic                             raw;
      logic                             over;
   } mwml_item_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } mwml_queue_stat_type;

endpackage

/* design/mwml_front.sv */
`timescale 1ns / 1ps

module mwml_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [mwml_pkg::REQ_DATA_W-1:0]   in_data,
   input  logic                              in_raw,
   input  mwml_pkg::mwml_cfg_type            cfg,
   output logic                              push,
   output mwml_pkg::mwml_item_type           push_item
);
   import mwml_pkg::*;

   logic signed [COEF_W-1:0]  coef_f_ff, coef_r_ff, coef_f_in, coef_r_in;

   logic                      s1_valid_ff, s1_raw_ff;
   logic signed [SPEED_W-1:0] s1_fwd_ff, s1_side_ff, s1_yaw_ff;

   logic                      s2_valid_ff, s2_raw_ff;
   logic signed [SPEED_W-1:0] s2_fwd_ff, s2_side_ff;
   logic signed [PROD_W-1:0]  s2_prod_f_ff, s2_prod_r_ff, s2_prod_f_in, s2_prod_r_in;

   logic                      s3_valid_ff, s3_raw_ff;
   logic signed [SPEED_W-1:0] s3_fwd_ff, s3_side_ff;
   logic signed [WHEEL_W-1:0] s3_rot_f_ff, s3_rot_r_ff;

   logic                      s4_valid_ff, s4_raw_ff;
   logic signed [WHEEL_W-1:0] s4_w_ff [NUM_WHEELS];
   logic signed [WHEEL_W-1:0] s4_w_in [NUM_WHEELS];

   logic                         s5_valid_ff, s5_raw_ff;
   logic [NUM_WHEELS-1:0]        s5_neg_ff, s5_neg_in;
   logic [MAG_W-1:0]             s5_mag_ff [NUM_WHEELS];
   logic [MAG_W-1:0]             s5_mag_in [NUM_WHEELS];
   logic [MAG_W-1:0]             s5_max01_ff, s5_max23_ff, s5_max01_in, s5_max23_in;
   logic [MAG_W-1:0]             peak;

   // Rounds a Q.46 product to Q16.16, halves away from zero.
   function automatic logic signed [WHEEL_W-1:0] round_q46(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0]  m;
      logic [PROD_W-1:0]  r;
      logic [WHEEL_W-1:0] q;
      m = p[PROD_W-1] ? (~p + 1'b1) : p;
      r = m + (PROD_W'(1) << (FRAC_SHIFT - 1));
      q = WHEEL_W'(r >> FRAC_SHIFT);
      return p[PROD_W-1] ? -$signed(q) : $signed(q);
   endfunction

   // The axle coefficients only follow the registers, so they are refreshed every cycle.
   always_comb begin
      logic signed [FACTOR_W-1:0] scale_x;
      logic signed [FACTOR_W-1:0] factor_f;
      logic signed [FACTOR_W-1:0] factor_r;
      logic signed [FACTOR_W-1:0] arm_x;
      scale_x   = FACTOR_W'($signed(cfg.rot_scale));
      factor_f  = scale_x - ONE_Q14;
      factor_r  = -scale_x - ONE_Q14;
      arm_x     = $signed({1'b0, cfg.lever_arm});
      coef_f_in = factor_f * arm_x;
      coef_r_in = factor_r * arm_x;
   end

   always_ff @(posedge clock) begin
      coef_f_ff <= coef_f_in;
      coef_r_ff <= coef_r_in;
   end

   assign s2_prod_f_in = coef_f_ff * s1_yaw_ff;
   assign s2_prod_r_in = coef_r_ff * s1_yaw_ff;

   always_comb begin
      logic signed [WHEEL_W-1:0] fwd_x;
      logic signed [WHEEL_W-1:0] side_x;
      fwd_x      = WHEEL_W'(s3_fwd_ff);
      side_x     = WHEEL_W'(s3_side_ff);
      s4_w_in[0] = -fwd_x - side_x + s3_rot_f_ff;
      s4_w_in[1] =  fwd_x - side_x + s3_rot_f_ff;
      s4_w_in[2] =  fwd_x + side_x + s3_rot_r_ff;
      s4_w_in[3] = -fwd_x + side_x + s3_rot_r_ff;
   end

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         s5_neg_in[i] = s4_w_ff[i][WHEEL_W-1];
         s5_mag_in[i] = s5_neg_in[i] ? MAG_W'(-s4_w_ff[i]) : MAG_W'(s4_w_ff[i]);
      end
      s5_max01_in = (s5_mag_in[0] > s5_mag_in[1]) ? s5_mag_in[0] : s5_mag_in[1];
      s5_max23_in = (s5_mag_in[2] > s5_mag_in[3]) ? s5_mag_in[2] : s5_mag_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_fwd_ff    <= $signed(in_data[SPEED_W-1:0]);
         s1_side_ff   <= $signed(in_data[2*SPEED_W-1:SPEED_W]);
         s1_yaw_ff    <= $signed(in_data[3*SPEED_W-1:2*SPEED_W]);
         s1_raw_ff    <= in_raw;

         s2_fwd_ff    <= s1_fwd_ff;
         s2_side_ff   <= s1_side_ff;
         s2_raw_ff    <= s1_raw_ff;
         s2_prod_f_ff <= s2_prod_f_in;
         s2_prod_r_ff <= s2_prod_r_in;

         s3_fwd_ff    <= s2_fwd_ff;
         s3_side_ff   <= s2_side_ff;
         s3_raw_ff    <= s2_raw_ff;
         s3_rot_f_ff  <= round_q46(s2_prod_f_ff);
         s3_rot_r_ff  <= round_q46(s2_prod_r_ff);

         s4_raw_ff    <= s3_raw_ff;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            s4_w_ff[i] <= s4_w_in[i];
         end

         s5_raw_ff    <= s4_raw_ff;
         s5_neg_ff    <= s5_neg_in;
         s5_max01_ff  <= s5_max01_in;
         s5_max23_ff  <= s5_max23_in;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            s5_mag_ff[i] <= s5_mag_in[i];
         end
      end
   end

   assign peak = (s5_max01_ff > s5_max23_ff) ? s5_max01_ff : s5_max23_ff;

   always_comb begin
      push_item.neg  = s5_neg_ff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         push_item.mag[i] = s5_mag_ff[i];
      end
      push_item.peak = peak;
      push_item.raw  = s5_raw_ff;
      push_item.over = !s5_raw_ff && (peak > MAG_W'(cfg.max_speed));
   end

   assign push = advance && s5_valid_ff;

endmodule

/* design/mwml_queue.sv */
`timescale 1ns / 1ps

module mwml_queue #(
   parameter int DEPTH = mwml_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  mwml_pkg::mwml_item_type       push_item,
   input  logic                          pop,
   output mwml_pkg::mwml_item_type       head_item,
   output mwml_pkg::mwml_queue_stat_type stat
);
   import mwml_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mwml_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item     = entry_ff[rd_ptr_ff];
   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.nonempty = (count_ff != '0);

endmodule

/* design/mwml_back.sv */
`timescale 1ns / 1ps

module mwml_back (
   input  logic                            clock,
   input  logic                            reset,
   input  mwml_pkg::mwml_cfg_type          cfg,
   input  mwml_pkg::mwml_item_type         head_item,
   input  mwml_pkg::mwml_queue_stat_type   q_stat,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mwml_pkg::RSP_DATA_W-1:0] rsp_data,
   output logic [mwml_pkg::RSP_USER_W-1:0] rsp_user
);
   import mwml_pkg::*;

   localparam int MUL_W = MAG_W + RATE_W;
   localparam logic [MAG_W-1:0] RAW_POS_CAP = MAG_W'(32767);
   localparam logic [MAG_W-1:0] RAW_NEG_CAP = MAG_W'(32768);
   localparam logic [MAG_W-1:0] Q_NEG_CAP   = MAG_W'(1) << (SPEED_W - 1);
   localparam logic [MAG_W-1:0] Q_POS_CAP   = Q_NEG_CAP - 1'b1;

   logic advance;

   logic [DIV_STAGES-1:0] dv_valid_ff;
   mwml_item_type         dv_item_ff [DIV_STAGES];
   logic [REM_W-1:0]      dv_rem_ff  [DIV_STAGES];
   logic [REM_W-1:0]      dv_rem_in  [DIV_STAGES];
   logic [RATE_W-1:0]     dv_quo_ff  [DIV_STAGES];
   logic [RATE_W-1:0]     dv_quo_in  [DIV_STAGES];

   logic                  ml_valid_ff;
   mwml_item_type         ml_item_ff;
   logic [MAG_W-1:0]      ml_scaled_ff [NUM_WHEELS];
   logic [MAG_W-1:0]      ml_scaled_in [NUM_WHEELS];

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   // Restoring division, two quotient bits per stage. The remainder starts at the
   // limit, which is below the divisor whenever the quotient is used.
   function automatic logic [REM_W+RATE_W-1:0] div_steps(input logic [REM_W-1:0]  rem,
                                                          input logic [RATE_W-1:0] quo,
                                                          input logic [MAG_W-1:0]  den);
      logic [REM_W-1:0]  r;
      logic [RATE_W-1:0] q;
      r = rem;
      q = quo;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
         r = {r[REM_W-2:0], 1'b0};
         if (r >= REM_W'(den)) begin
            r = r - REM_W'(den);
            q = {q[RATE_W-2:0], 1'b1};
         end else begin
            q = {q[RATE_W-2:0], 1'b0};
         end
      end
      return {r, q};
   endfunction

   function automatic logic [SPEED_W-1:0] wheel_value(input logic             neg,
                                                      input logic [MAG_W-1:0] mag,
                                                      input logic [MAG_W-1:0] scaled,
                                                      input logic             raw,
                                                      input logic             over);
      logic [MAG_W-1:0]   m;
      logic [MAG_W-1:0]   cap;
      logic [SPEED_W-1:0] u;
      if (raw) begin
         m   = mag >> RAW_SHIFT;
         cap = neg ? RAW_NEG_CAP : RAW_POS_CAP;
      end else begin
         m   = over ? scaled : mag;
         cap = neg ? Q_NEG_CAP : Q_POS_CAP;
      end
      if (m > cap) begin
         m = cap;
      end
      u = m[SPEED_W-1:0];
      return neg ? (~u + 1'b1) : u;
   endfunction

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && q_stat.nonempty;

   always_comb begin
      {dv_rem_in[0], dv_quo_in[0]} = div_steps(REM_W'(cfg.max_speed), '0, head_item.peak);
      for (int k = 1; k < DIV_STAGES; k++) begin
         {dv_rem_in[k], dv_quo_in[k]} = div_steps(dv_rem_ff[k-1], dv_quo_ff[k-1],
                                                  dv_item_ff[k-1].peak);
      end
   end

   always_comb begin
      logic [MUL_W-1:0] prod;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         prod            = dv_item_ff[DIV_STAGES-1].mag[i] * dv_quo_ff[DIV_STAGES-1];
         ml_scaled_in[i] = MAG_W'(prod >> RATE_SHIFT);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         rsp_data_in[i*SPEED_W +: SPEED_W] = wheel_value(ml_item_ff.neg[i], ml_item_ff.mag[i],
                                                         ml_scaled_ff[i], ml_item_ff.raw,
                                                         ml_item_ff.over);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff  <= '0;
         ml_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         dv_valid_ff  <= {dv_valid_ff[DIV_STAGES-2:0], q_stat.nonempty};
         ml_valid_ff  <= dv_valid_ff[DIV_STAGES-1];
         rsp_valid_ff <= ml_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_item_ff[0] <= head_item;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dv_item_ff[k] <= dv_item_ff[k-1];
         end
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_quo_ff[k] <= dv_quo_in[k];
         end
         ml_item_ff <= dv_item_ff[DIV_STAGES-1];
         for (int i = 0; i < NUM_WHEELS; i++) begin
            ml_scaled_ff[i] <= ml_scaled_in[i];
         end
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= {ml_item_ff.over, ml_item_ff.raw};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_user  = rsp_user_ff;

endmodule

/* design/mecanum_wheel_mixer_limit.sv */
`timescale 1ns / 1ps
`include "mecanum_wheel_mixer_limit_assert.svh"

// Four-wheel mecanum mixer with a wheel speed limiter. Each chassis command (forward,
// sideways and yaw rate in signed Q16.16, plus a raw flag) gives one beat of four wheel
// values. A new command is taken every cycle while the result side keeps up; the limiter
// ratio comes from a divider pipelined at two quotient bits per stage, and that divider
// sets the depth of the block rather than its rate. Without stalls a command passes from
// the accepting edge through the mixing stages, the queue, the divider, the scaling
// multiply and the output register to the result beat. The mixing front end keeps running
// into the queue while the result side is stalled, so up to QUEUE_DEPTH commands are
// absorbed before req_tready falls. In raw mode the outputs are the integer parts clamped
// to 16 bits and nothing is limited. The user must write registers through the csr port
// only while no command is in flight; the block itself does not enforce it.
module mecanum_wheel_mixer_limit #(
   parameter int QUEUE_DEPTH = mwml_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // forward_speed [31:0], sideways_speed [63:32], yaw_rate [95:64]
   input  logic [mwml_pkg::REQ_DATA_W-1:0]  req_tdata,
   // raw_mode
   input  logic                             req_tuser,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // wheel_front_a [31:0], wheel_front_b [63:32], wheel_rear_a [95:64],
   // wheel_rear_b [127:96]
   output logic [mwml_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // was_raw [0], limited [1]
   output logic [mwml_pkg::RSP_USER_W-1:0]  rsp_tuser,

   input  logic                             csr_wen,
   input  logic [mwml_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mwml_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mwml_pkg::*;

   mwml_cfg_type        cfg_ff;
   mwml_item_type       q_push_item;
   mwml_item_type       q_head_item;
   mwml_queue_stat_type q_stat;
   logic                q_push;
   logic                q_pop;
   logic                front_adv;

   logic signed [SPEED_W-1:0] limit_s;
   logic signed [SPEED_W-1:0] wheel0_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_scale <= ROT_SCALE_RESET;
         cfg_ff.lever_arm <= LEVER_ARM_RESET;
         cfg_ff.max_speed <= MAX_SPEED_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ROT_SCALE: cfg_ff.rot_scale <= csr_wdata[SCALE_W-1:0];
            CSR_LEVER_ARM: cfg_ff.lever_arm <= csr_wdata[ARM_W-1:0];
            CSR_MAX_SPEED: cfg_ff.max_speed <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // The front end moves as a whole whenever the queue can take its oldest command.
   assign front_adv  = !q_stat.full || q_pop;
   assign req_tready = front_adv;

   mwml_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (front_adv),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .in_raw    (req_tuser),
      .cfg       (cfg_ff),
      .push      (q_push),
      .push_item (q_push_item)
   );

   mwml_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .stat      (q_stat)
   );

   mwml_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_item (q_head_item),
      .q_stat    (q_stat),
      .pop       (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_user  (rsp_tuser)
   );

   assign limit_s  = $signed({1'b0, cfg_ff.max_speed});
   assign wheel0_s = $signed(rsp_tdata[SPEED_W-1:0]);

   `MWML_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, q_push && q_stat.full, q_pop, "queue written while full")
   `MWML_ASSERT_IMPLY(a_raw_range, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1] && wheel0_s >= -32'sd32768 && wheel0_s <= 32'sd32767, "raw beat out of 16-bit range or marked limited")
   `MWML_ASSERT_IMPLY(a_limited_bound, clock, reset, rsp_tvalid && rsp_tuser[1], wheel0_s <= limit_s && wheel0_s >= -limit_s, "limited beat exceeds the speed limit")
   `MWML_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_tvalid && !q_stat.nonempty, "pipeline not empty after reset")

endmodule
